### src/bpe_pkg.sv
`timescale 1ns / 1ps
// bpe_pkg: shared constants and pipeline control struct for the bezier point evaluator
// no dependencies

package bpe_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int T_FRAC_BITS_DEF = 16;

    // control points per item and pipeline depth (three lerp levels, two stages each)
    localparam int NUM_POINTS = 4;
    localparam int NUM_STAGES = 6;

    typedef enum logic {
        OP_QUADRATIC = 1'b0,
        OP_CUBIC     = 1'b1
    } t_op;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctl;

endpackage

### src/bezier_point_evaluator.sv
`timescale 1ns / 1ps
// bezier_point_evaluator: pipelined de casteljau point evaluation, quadratic or cubic, 2-d
// depends on bpe_pkg, bpe_lerp, bpe_ctrl
//
//  channel  dir  signals                       contents
//  s        in   i_s_tvalid/o_s_tready         tdata: control points, t; tuser: op
//  m        out  o_m_tvalid/i_m_tready         tdata: evaluated point
//
// six register stages, two per interpolation level; one transfer per cycle while the output is not stalled
// quadratic items pass the last level as a lerp between equal points
// reset clears only the stage valid bits
// a stalled output holds its stage; upstream stages keep filling bubbles

module bezier_point_evaluator
    import bpe_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int S_DATA_W = ((2 * NUM_POINTS * COORD_WIDTH + T_FRAC_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, t_frac
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // op
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // out_x, out_y
    output logic [M_DATA_W-1:0] o_m_tdata
);

    localparam int T_STAGES = NUM_STAGES - 2;

    t_pipe_ctl w_ctl;

    logic signed [COORD_WIDTH-1:0] w_pt  [NUM_POINTS][2];
    logic        [T_FRAC_BITS-1:0] w_t;
    logic signed [COORD_WIDTH-1:0] w_l1  [2][NUM_POINTS-1];
    logic signed [COORD_WIDTH-1:0] w_l2  [2][NUM_POINTS-2];
    logic signed [COORD_WIDTH-1:0] w_l3b [2];
    logic signed [COORD_WIDTH-1:0] w_out [2];
    logic        [T_FRAC_BITS-1:0] r_t   [T_STAGES];
    t_op                           r_op  [T_STAGES];

    bpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_ctl      (w_ctl)
    );

    always_comb begin
        for (int j = 0; j < NUM_POINTS; j++) begin
            for (int ax = 0; ax < 2; ax++) begin
                w_pt[j][ax] = i_s_tdata[(2 * j + ax) * COORD_WIDTH +: COORD_WIDTH];
            end
        end
        w_t = i_s_tdata[2 * NUM_POINTS * COORD_WIDTH +: T_FRAC_BITS];
    end

    // t and op travel beside the first two levels
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_t[0]  <= w_t;
            r_op[0] <= t_op'(i_s_tuser);
        end
        for (int k = 1; k < T_STAGES; k++) begin
            if (w_ctl.en[k]) begin
                r_t[k]  <= r_t[k-1];
                r_op[k] <= r_op[k-1];
            end
        end
    end

    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        for (genvar j = 0; j < NUM_POINTS - 1; j++) begin : g_l1
            bpe_lerp #(
                .COORD_WIDTH (COORD_WIDTH),
                .T_FRAC_BITS (T_FRAC_BITS)
            ) u_lerp (
                .i_clk    (i_clk),
                .i_en_mul (w_ctl.en[0]),
                .i_en_add (w_ctl.en[1]),
                .i_a      (w_pt[j][ax]),
                .i_b      (w_pt[j+1][ax]),
                .i_t      (w_t),
                .o_y      (w_l1[ax][j])
            );
        end

        for (genvar j = 0; j < NUM_POINTS - 2; j++) begin : g_l2
            bpe_lerp #(
                .COORD_WIDTH (COORD_WIDTH),
                .T_FRAC_BITS (T_FRAC_BITS)
            ) u_lerp (
                .i_clk    (i_clk),
                .i_en_mul (w_ctl.en[2]),
                .i_en_add (w_ctl.en[3]),
                .i_a      (w_l1[ax][j]),
                .i_b      (w_l1[ax][j+1]),
                .i_t      (r_t[1]),
                .o_y      (w_l2[ax][j])
            );
        end

        // quadratic result is already complete after the second level
        assign w_l3b[ax] = (r_op[3] == OP_CUBIC) ? w_l2[ax][1] : w_l2[ax][0];

        bpe_lerp #(
            .COORD_WIDTH (COORD_WIDTH),
            .T_FRAC_BITS (T_FRAC_BITS)
        ) u_lerp_l3 (
            .i_clk    (i_clk),
            .i_en_mul (w_ctl.en[4]),
            .i_en_add (w_ctl.en[5]),
            .i_a      (w_l2[ax][0]),
            .i_b      (w_l3b[ax]),
            .i_t      (r_t[3]),
            .o_y      (w_out[ax])
        );
    end

    assign o_m_tvalid = w_ctl.valid[NUM_STAGES-1];
    assign o_m_tdata  = M_DATA_W'({w_out[1], w_out[0]});

`ifndef SYNTHESIS
    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready
    ) else $error("input stalled while output stage empty");

    a_accept_enters_stage0: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> w_ctl.valid[0]
    ) else $error("accepted transfer not captured in first stage");

    a_drain_without_feed: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !w_ctl.valid[NUM_STAGES-2]) |=> !o_m_tvalid
    ) else $error("result repeated after output transfer");
`endif

endmodule

### src/bpe_lerp.sv
`timescale 1ns / 1ps
// bpe_lerp: two-stage linear interpolation a + (b - a) * t, truncated toward zero
// depends on bpe_pkg

module bpe_lerp
    import bpe_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en_mul,
    input  logic                          i_en_add,
    input  logic signed [COORD_WIDTH-1:0] i_a,
    input  logic signed [COORD_WIDTH-1:0] i_b,
    input  logic        [T_FRAC_BITS-1:0] i_t,
    output logic signed [COORD_WIDTH-1:0] o_y
);

    localparam int NUM_W = COORD_WIDTH + T_FRAC_BITS + 2;

    logic signed [COORD_WIDTH:0]   w_diff;
    logic signed [NUM_W-1:0]       w_prod;
    logic signed [COORD_WIDTH-1:0] r_a;
    logic signed [NUM_W-1:0]       r_prod;
    logic        [NUM_W-1:0]       w_num;
    logic        [NUM_W-1:0]       w_bias;
    logic        [NUM_W-1:0]       w_adj;
    logic signed [COORD_WIDTH-1:0] r_y;

    assign w_diff = {i_b[COORD_WIDTH-1], i_b} - {i_a[COORD_WIDTH-1], i_a};
    assign w_prod = NUM_W'(w_diff) * NUM_W'($signed({1'b0, i_t}));

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_a    <= i_a;
            r_prod <= w_prod;
        end
    end

    // negative numerator gets 2^F - 1 added so the shift truncates toward zero
    assign w_num  = {{2{r_a[COORD_WIDTH-1]}}, r_a, {T_FRAC_BITS{1'b0}}} + r_prod;
    assign w_bias = {{(COORD_WIDTH + 2){1'b0}}, {T_FRAC_BITS{1'b1}}}
                    & {NUM_W{w_num[NUM_W-1]}};
    assign w_adj  = w_num + w_bias;

    always_ff @(posedge i_clk) begin
        if (i_en_add) begin
            r_y <= w_adj[T_FRAC_BITS +: COORD_WIDTH];
        end
    end

    assign o_y = r_y;

endmodule

### src/bpe_ctrl.sv
`timescale 1ns / 1ps
// bpe_ctrl: stage valid bits and per-stage enables with bubble collapse
// depends on bpe_pkg

module bpe_ctrl
    import bpe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_tvalid,
    input  logic      i_m_tready,
    output logic      o_s_tready,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] w_en;

    always_comb begin
        w_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
        n_valid[0] = w_en[0] ? i_s_tvalid : r_valid[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = w_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_s_tready  = w_en[0];
    assign o_ctl.en    = w_en;
    assign o_ctl.valid = r_valid;

endmodule

### tb/bezier_point_evaluator_tb.sv
`timescale 1ns / 1ps
// bezier_point_evaluator_tb: self-checking bench for the de casteljau point evaluator
// predicts each point from its control points and t, compares against the output stream
// depends on bpe_pkg and bezier_point_evaluator

module bezier_point_evaluator_tb;
    import bpe_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int TW          = T_FRAC_BITS_DEF;
    localparam int S_W         = ((NUM_POINTS * 2 * CW + TW + 7) / 8) * 8;
    localparam int M_W         = ((2 * CW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 110;

    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};
    localparam logic [TW-1:0] THALF = {1'b1, {(TW-1){1'b0}}};

    typedef struct packed {
        t_op                           op;
        logic [NUM_POINTS-1:0][CW-1:0] px;
        logic [NUM_POINTS-1:0][CW-1:0] py;
        logic [TW-1:0]                 t;
        logic [3:0]                    gap;
        logic                          drain;
    } t_curve_req;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_s_tvalid;
    logic           o_s_tready;
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, t_frac
    logic [S_W-1:0] i_s_tdata;
    // op
    logic           i_s_tuser;
    logic           o_m_tvalid;
    logic           i_m_tready;
    // out_x, out_y
    logic [M_W-1:0] o_m_tdata;

    t_curve_req     req_q[$];
    logic [2*CW-1:0] point_q[$];
    t_curve_req     cur_req;
    int             n_issued;
    int             n_accepted;
    int             n_points;
    int             n_points_seen;
    int             gap_cnt;
    int             rx_wait;
    int             tx_idle_max;
    int             rx_idle_max;
    int             n_errors;
    int             cycle_cnt;
    bit             drain_next;

    bezier_point_evaluator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // a + (b - a) * t, truncated toward zero
    function automatic longint lerp_trunc(longint a, longint b, longint t);
        longint scale;
        scale = longint'(1) << TW;
        return (a * scale + (b - a) * t) / scale;
    endfunction

    function automatic logic [CW-1:0] eval_axis(t_op op, logic [NUM_POINTS-1:0][CW-1:0] c,
                                                 logic [TW-1:0] t);
        longint a, b, cc, d, tt, ab, bc, cd, abc, bcd, r;
        a  = longint'($signed(c[0]));
        b  = longint'($signed(c[1]));
        cc = longint'($signed(c[2]));
        d  = longint'($signed(c[3]));
        tt = longint'(t);
        ab = lerp_trunc(a, b, tt);
        bc = lerp_trunc(b, cc, tt);
        if (op == OP_QUADRATIC) begin
            r = lerp_trunc(ab, bc, tt);
        end else begin
            cd  = lerp_trunc(cc, d, tt);
            abc = lerp_trunc(ab, bc, tt);
            bcd = lerp_trunc(bc, cd, tt);
            r   = lerp_trunc(abc, bcd, tt);
        end
        return r[CW-1:0];
    endfunction

    function automatic logic [2*CW-1:0] eval_point(t_curve_req r);
        return {eval_axis(r.op, r.py, r.t), eval_axis(r.op, r.px, r.t)};
    endfunction

    task automatic flag_error(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    task automatic add_curve(t_op op, logic [CW-1:0] x0, logic [CW-1:0] y0,
                             logic [CW-1:0] x1, logic [CW-1:0] y1,
                             logic [CW-1:0] x2, logic [CW-1:0] y2,
                             logic [CW-1:0] x3, logic [CW-1:0] y3, logic [TW-1:0] t);
        t_curve_req r;
        r.op    = op;
        r.px    = {x3, x2, x1, x0};
        r.py    = {y3, y2, y1, y0};
        r.t     = t;
        r.gap   = 4'($urandom_range(0, tx_idle_max));
        r.drain = drain_next;
        drain_next = 1'b0;
        req_q.push_back(r);
    endtask

    // extremes and near-zero values show up often, the rest is uniform
    function automatic logic [CW-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return CMIN;
            1: return CMAX;
            2: return CW'($urandom_range(0, 15) - 8);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [TW-1:0] rand_t();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return TMAX;
            2: return TW'($urandom_range(0, 3));
            default: return TW'($urandom);
        endcase
    endfunction

    // sender
    always @(negedge i_clk) begin
        logic           nxt_valid;
        logic [S_W-1:0] data;
        nxt_valid = i_s_tvalid;
        if (i_rst_n) begin
            if (i_s_tvalid && n_accepted == n_issued) nxt_valid = 1'b0;
            if (!nxt_valid && req_q.size() != 0) begin
                if (req_q[0].drain && point_q.size() != 0) begin
                    gap_cnt = 0;
                end else if (gap_cnt < req_q[0].gap) begin
                    gap_cnt++;
                end else begin
                    cur_req = req_q.pop_front();
                    gap_cnt = 0;
                    data    = '0;
                    for (int i = 0; i < NUM_POINTS; i++) begin
                        data[2*CW*i +: CW]      = cur_req.px[i];
                        data[2*CW*i + CW +: CW] = cur_req.py[i];
                    end
                    data[2*CW*NUM_POINTS +: TW] = cur_req.t;
                    i_s_tdata <= data;
                    i_s_tuser <= cur_req.op;
                    n_issued++;
                    nxt_valid = 1'b1;
                end
            end
        end
        i_s_tvalid <= nxt_valid;
    end

    // receiver: a fresh random stall, possibly none, after every point transfer
    always @(negedge i_clk) begin
        if (n_points != n_points_seen) begin
            n_points_seen = n_points;
            rx_wait       = $urandom_range(0, rx_idle_max);
        end
        if (rx_wait != 0) begin
            rx_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [2*CW-1:0] exp_pt;
        logic [CW-1:0]   got_x, got_y;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                point_q.push_back(eval_point(cur_req));
                n_accepted++;
            end
            if (o_m_tvalid && i_m_tready) begin
                n_points++;
                got_x = o_m_tdata[CW-1:0];
                got_y = o_m_tdata[2*CW-1:CW];
                if (point_q.size() == 0) begin
                    flag_error($sformatf("point %0d: unexpected x=%0d y=%0d", n_points,
                                         $signed(got_x), $signed(got_y)));
                end else begin
                    exp_pt = point_q.pop_front();
                    if (got_x !== exp_pt[CW-1:0])
                        flag_error($sformatf("point %0d: out_x %0d, expected %0d", n_points,
                                             $signed(got_x), $signed(exp_pt[CW-1:0])));
                    if (got_y !== exp_pt[2*CW-1:CW])
                        flag_error($sformatf("point %0d: out_y %0d, expected %0d", n_points,
                                             $signed(got_y), $signed(exp_pt[2*CW-1:CW])));
                end
            end
        end
    end

    initial begin
        t_op op;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = 1'b0;
        i_m_tready    = 1'b0;
        cur_req       = '0;
        n_issued      = 0;
        n_accepted    = 0;
        n_points      = 0;
        n_points_seen = 0;
        gap_cnt       = 0;
        rx_wait       = 0;
        n_errors      = 0;
        cycle_cnt     = 0;
        drain_next    = 1'b0;
        tx_idle_max   = 3;
        rx_idle_max   = 3;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: t at both ends, extreme coordinates, truncation of negative values
        add_curve(OP_QUADRATIC, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        add_curve(OP_QUADRATIC, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, '0);
        add_curve(OP_QUADRATIC, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, TMAX);
        add_curve(OP_CUBIC, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, '0);
        add_curve(OP_CUBIC, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, TMAX);
        add_curve(OP_CUBIC, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, THALF);
        add_curve(OP_CUBIC, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, TW'(1234));
        add_curve(OP_CUBIC, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, TMAX);
        add_curve(OP_QUADRATIC, '0, '0, CW'(-1), CW'(-1), CW'(-1), CW'(-1), '0, '0, THALF);
        add_curve(OP_QUADRATIC, '0, '0, CW'(1), CW'(1), CW'(1), CW'(1), '0, '0, THALF);
        add_curve(OP_CUBIC, '0, '0, '0, '0, '0, '0, CMAX, CMIN, TMAX);
        add_curve(OP_QUADRATIC, '0, '0, '0, '0, '0, '0, CMAX, CMIN, TMAX);
        add_curve(OP_CUBIC, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, TW'(1));
        add_curve(OP_QUADRATIC, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN,
                  THALF - TW'(1));
        add_curve(OP_CUBIC, CW'(-3), CW'(5), CW'(7), CW'(-9), CW'(-11), CW'(13), CW'(15),
                  CW'(-17), TMAX - TW'(1));
        add_curve(OP_QUADRATIC, CW'(-3), CW'(5), CW'(7), CW'(-9), CW'(-11), CW'(13), CW'(15),
                  CW'(-17), TW'(3));
        while (req_q.size() != 0) @(posedge i_clk);

        // random phases, each opening with a full drain of the pipeline
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin tx_idle_max = 15; rx_idle_max = 15; end
                1: begin tx_idle_max = 0;  rx_idle_max = 0;  end
                2: begin tx_idle_max = 0;  rx_idle_max = 15; end
                3: begin tx_idle_max = 15; rx_idle_max = 0;  end
                default: begin tx_idle_max = 7; rx_idle_max = 7; end
            endcase
            drain_next = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                op = t_op'($urandom_range(0, 1));
                add_curve(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_t());
            end
            while (req_q.size() != 0) @(posedge i_clk);
        end

        while (i_s_tvalid || point_q.size() != 0) @(posedge i_clk);
        repeat (NUM_STAGES * 4) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### bezier_point_evaluator.f
src/bpe_pkg.sv
src/bpe_lerp.sv
src/bpe_ctrl.sv
src/bezier_point_evaluator.sv
tb/bezier_point_evaluator_tb.sv
